@@ hdl/top_n_preference_select_top_defines.svh @@
// ----------------------------------------------------------------------------
// Top-N preference select: assertion macros
// Shared property macros for the concurrent checks in the top level.
// ----------------------------------------------------------------------------
`ifndef TOP_N_PREFERENCE_SELECT_TOP_DEFINES_SVH
`define TOP_N_PREFERENCE_SELECT_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TNPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define TNPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/tnps_pkg.sv @@
// ----------------------------------------------------------------------------
// Top-N preference select package
// Entry and control types shared by the selection cells and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tnps_pkg;

    localparam int VALUE_W = 16;
    localparam int INDEX_W = 8;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_SHIFT  = 2'd2,
        CELL_CLEAR  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } t_entry;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [VALUE_W-1:0] value;
        logic [INDEX_W-1:0]        index;
    } t_cell_ctrl;

endpackage

@@ hdl/top_n_preference_select_top.sv @@
// ----------------------------------------------------------------------------
// Top-N preference select: top level
// An item among the first MAX_CHOICES of a list is ranked at its accepting edge;
// once the last item is accepted, the report state is entered and the first slot
// is registered. One item per cycle in a list; the report then emits one slot per
// cycle while the output is not stalled, one per seat in use, and accepts no item.
// Reset clears the list, arrival count and report state and sets seats_in_use to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "top_n_preference_select_top_defines.svh"

module top_n_preference_select_top
    import tnps_pkg::*;
#(
    parameter int MAX_SEATS   = 8,
    parameter int MAX_CHOICES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] pref_value
    input  logic        s_axis_tlast,
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] choice_index, [23:8] rank_value
    output logic        m_axis_tuser,   // [0] slot_valid
    output logic        m_axis_tlast
);

    localparam int SW = $clog2(MAX_SEATS + 1);
    localparam int CW = $clog2(MAX_CHOICES + 1);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [3:0]        r_seats;
    logic [CW-1:0]     r_cnt;
    logic [SW-1:0]     r_slot;
    logic              r_out_valid;
    t_entry            r_out;
    logic              r_out_last;

    logic [SW-1:0]     w_seats;
    logic              w_room;
    logic              w_in_acc;
    logic              w_load;
    logic              w_final;
    t_cell_ctrl        w_ctrl;
    t_entry            w_ent [MAX_SEATS];
    logic              w_ge [MAX_SEATS];
    logic [MAX_SEATS-1:0] w_valid;
    logic [MAX_SEATS:0]   w_valid_inc;

    // Configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seats <= 4'd1;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_seats <= pwdata[3:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {28'd0, r_seats};

    always_comb begin
        if (r_seats == 4'd0) begin
            w_seats = SW'(1);
        end else if (32'(r_seats) > MAX_SEATS) begin
            w_seats = SW'(MAX_SEATS);
        end else begin
            w_seats = SW'(r_seats);
        end
    end

    // Handshakes and sequencing
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_room        = r_cnt < CW'(MAX_CHOICES);
    assign w_load        = (r_state == ST_REPORT) && (!r_out_valid || m_axis_tready);
    assign w_final       = (SW'(r_slot + 1'b1) == w_seats);

    always_comb begin
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.value = $signed(s_axis_tdata[15:0]);
        w_ctrl.index = INDEX_W'(r_cnt);
        n_state      = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_room) begin
                        w_ctrl.op = CELL_INSERT;
                    end
                    if (s_axis_tlast) begin
                        n_state = ST_REPORT;
                    end
                end
            end
            ST_REPORT: begin
                if (w_load) begin
                    w_ctrl.op = w_final ? CELL_CLEAR : CELL_SHIFT;
                    if (w_final) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (s_axis_tlast) begin
                    r_cnt <= '0;
                end else if (w_room) begin
                    r_cnt <= CW'(r_cnt + 1'b1);
                end
            end
            if (w_load) begin
                r_slot      <= w_final ? '0 : SW'(r_slot + 1'b1);
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out      <= w_ent[0];
            r_out_last <= w_final;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = r_out.valid ? {r_out.value, r_out.index} : 24'd0;

    // Ranking chain
    for (genvar k = 0; k < MAX_SEATS; k++) begin : g_cell
        logic   w_en;
        logic   w_left_ge;
        t_entry w_left;
        t_entry w_right;

        assign w_en = (SW'(k) < w_seats);

        if (k == 0) begin : g_head
            assign w_left_ge = 1'b1;
            assign w_left    = '0;
        end else begin : g_body
            assign w_left_ge = w_ge[k-1];
            assign w_left    = w_ent[k-1];
        end

        if (k == MAX_SEATS - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_ent[k+1];
        end

        tnps_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_en      (w_en),
            .i_left    (w_left),
            .i_left_ge (w_left_ge),
            .i_right   (w_right),
            .o_entry   (w_ent[k]),
            .o_ge      (w_ge[k])
        );

        assign w_valid[k] = w_ent[k].valid;
    end

    assign w_valid_inc = {1'b0, w_valid} + (MAX_SEATS + 1)'(1);

    // Checks
    `TNPS_ASSERT_NXT(a_last_starts_report, w_in_acc && s_axis_tlast, (r_state == ST_REPORT) && (r_cnt == '0), "Last transaction did not start a report.")
    `TNPS_ASSERT_NXT(a_final_slot_marked, w_load && w_final, m_axis_tvalid && m_axis_tlast, "Final rank slot left without last mark.")
    `TNPS_ASSERT_IMP(a_valid_prefix, 1'b1, $onehot(w_valid_inc), "Valid rank slots are not contiguous from the head.")

endmodule

@@ hdl/tnps_cell.sv @@
// ----------------------------------------------------------------------------
// Top-N preference select: ranking cell
// Holds one rank slot. Insert keeps its entry, takes the new value or the
// left neighbor's, or clears if disabled; report takes the right or clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tnps_cell
    import tnps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_en,
    input  t_entry     i_left,
    input  logic       i_left_ge,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_ge
);

    logic                      r_valid;
    logic signed [VALUE_W-1:0] r_value;
    logic [INDEX_W-1:0]        r_index;
    logic                      n_valid;
    logic signed [VALUE_W-1:0] n_value;
    logic [INDEX_W-1:0]        n_index;

    assign o_ge    = i_en && r_valid && (r_value >= i_ctrl.value);
    assign o_entry = '{valid: r_valid, value: r_value, index: r_index};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_index = r_index;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (!i_en) begin
                    n_valid = 1'b0;
                end else if (o_ge) begin
                    n_valid = r_valid;
                end else if (i_left_ge) begin
                    n_valid = 1'b1;
                    n_value = i_ctrl.value;
                    n_index = i_ctrl.index;
                end else begin
                    n_valid = i_left.valid;
                    n_value = i_left.value;
                    n_index = i_left.index;
                end
            end
            CELL_SHIFT: begin
                n_valid = i_right.valid;
                n_value = i_right.value;
                n_index = i_right.index;
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_index <= n_index;
    end

endmodule
